// File: rtl/ising1d_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ising1d_pkg
// Shared widths, register codes and configuration struct for the 1D Ising
// Metropolis update block.
// ----------------------------------------------------------------------------
package ising1d_pkg;

  localparam int N_SITES = 1024;
  localparam int SITE_W  = 10;
  localparam int ROWS    = N_SITES / 2;
  localparam int ROW_W   = $clog2(ROWS);
  localparam int DRAW_W  = 16;
  localparam int Q_W     = 16;
  localparam int THR_W   = 17;
  localparam int LOC_W   = 18;
  localparam int DE_W    = 19;
  localparam int E_W     = 40;
  localparam int SUM_W   = 12;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [SITE_W:0]     SITE_LIMIT = (SITE_W + 1)'(N_SITES);
  localparam logic [SITE_W-1:0]   SITE_LAST  = SITE_W'(N_SITES - 1);
  localparam logic [SUM_W-1:0]    SUM_RESET  = SUM_W'(N_SITES);
  localparam logic [Q_W-1:0]      J_RESET    = Q_W'(256);
  localparam logic [THR_W-1:0]    THR_RESET  = THR_W'(65536);
  localparam logic signed [E_W-1:0] E_MAX    = {1'b0, {(E_W - 1){1'b1}}};
  localparam logic signed [E_W-1:0] E_MIN    = {1'b1, {(E_W - 1){1'b0}}};

  typedef enum logic [2:0] {
    REG_COUPLING,
    REG_FIELD,
    REG_UP_NEG,
    REG_UP_ZERO,
    REG_UP_POS,
    REG_DOWN_NEG,
    REG_DOWN_ZERO,
    REG_DOWN_POS
  } reg_idx_t;

  // thresholds indexed by neighbour sum: 0 = -2, 1 = 0, 2 = +2
  typedef struct packed {
    logic signed [Q_W-1:0]   coupling;
    logic signed [Q_W-1:0]   field;
    logic [2:0][THR_W-1:0]   thr_up;
    logic [2:0][THR_W-1:0]   thr_down;
  } cfg_t;

endpackage
`default_nettype wire

// File: rtl/ising1d_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ising1d_ram
// Generic RAM, one write port and two read ports, registered read data.
// ----------------------------------------------------------------------------
module ising1d_ram #(
  parameter int DEPTH = 512,
  parameter int DW    = 1,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr_a,
  input  wire logic [AW-1:0] raddr_b,
  output logic      [DW-1:0] rdata_a,
  output logic      [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ising1d_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ising1d_regs
// APB register file: coupling, field and the six acceptance thresholds.
// ----------------------------------------------------------------------------
module ising1d_regs (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [ising1d_pkg::PADDR_W-1:0] paddr,
  input  wire logic [ising1d_pkg::PDATA_W-1:0] pwdata,
  output logic      [ising1d_pkg::PDATA_W-1:0] prdata,
  output logic                                 pready,
  output ising1d_pkg::cfg_t                    cfg
);
  import ising1d_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coupling <= J_RESET;
      cfg.field    <= '0;
      cfg.thr_up   <= {3{THR_RESET}};
      cfg.thr_down <= {3{THR_RESET}};
    end else if (wr) begin
      case (idx)
        REG_COUPLING:  cfg.coupling    <= pwdata[Q_W-1:0];
        REG_FIELD:     cfg.field       <= pwdata[Q_W-1:0];
        REG_UP_NEG:    cfg.thr_up[0]   <= pwdata[THR_W-1:0];
        REG_UP_ZERO:   cfg.thr_up[1]   <= pwdata[THR_W-1:0];
        REG_UP_POS:    cfg.thr_up[2]   <= pwdata[THR_W-1:0];
        REG_DOWN_NEG:  cfg.thr_down[0] <= pwdata[THR_W-1:0];
        REG_DOWN_ZERO: cfg.thr_down[1] <= pwdata[THR_W-1:0];
        REG_DOWN_POS:  cfg.thr_down[2] <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_COUPLING:  prdata = PDATA_W'(cfg.coupling);
      REG_FIELD:     prdata = PDATA_W'(cfg.field);
      REG_UP_NEG:    prdata = PDATA_W'(cfg.thr_up[0]);
      REG_UP_ZERO:   prdata = PDATA_W'(cfg.thr_up[1]);
      REG_UP_POS:    prdata = PDATA_W'(cfg.thr_up[2]);
      REG_DOWN_NEG:  prdata = PDATA_W'(cfg.thr_down[0]);
      REG_DOWN_ZERO: prdata = PDATA_W'(cfg.thr_down[1]);
      REG_DOWN_POS:  prdata = PDATA_W'(cfg.thr_down[2]);
      default:       prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/ising_1d_metropolis_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ising_1d_metropolis_update
// Metropolis spin update on a periodic 1D Ising ring held in two spin banks.
//
// Input words (site, proposed_spin, uniform_draw) enter on in_valid/in_stall;
// one result word (accepted, delta_energy, energy_total, spin_sum) leaves per
// input on out_valid/out_stall. Sites are split into an even and an odd bank
// of 512 entries; the two neighbours of a site sit in the opposite bank and
// are read on its two read ports, the site itself on one port of its own bank.
// Throughput is one word per cycle while out_stall is low, after the clearing pass.
// Path from accept: RAM read at the accept edge, stage 1 decision and write back,
// stage 2 hold, then energy accumulation into the output register.
// A write from the decision stage is forwarded to the word behind it.
// After reset the block runs a pass over all 512 rows setting every spin up and holds
// in_stall high meanwhile; register writes are taken during the pass.
// When out_stall is high the output word holds and the pipeline fills; with
// all three stages full in_stall rises in the same cycle.
// Registers sit on the APB port at byte address 4*index, pready always high.
// ----------------------------------------------------------------------------
module ising_1d_metropolis_update (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [ising1d_pkg::SITE_W-1:0]      site,
  input  wire logic                                proposed_spin,
  input  wire logic [ising1d_pkg::DRAW_W-1:0]      uniform_draw,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     accepted,
  output logic signed [ising1d_pkg::DE_W-1:0]      delta_energy,
  output logic signed [ising1d_pkg::E_W-1:0]       energy_total,
  output logic signed [ising1d_pkg::SUM_W-1:0]     spin_sum,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [ising1d_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [ising1d_pkg::PDATA_W-1:0]     pwdata,
  output logic      [ising1d_pkg::PDATA_W-1:0]     prdata,
  output logic                                     pready
);
  import ising1d_pkg::*;

  cfg_t cfg;

  ising1d_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // clearing pass
  logic             clr_active;
  logic [ROW_W-1:0] clr_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_row    <= '0;
    end else if (clr_active) begin
      clr_row <= clr_row + 1'b1;
      if (clr_row == ROW_W'(ROWS - 1)) begin
        clr_active <= 1'b0;
      end
    end
  end

  // handshake
  logic s1_valid, s2_valid;
  logic out_ready, s2_ready, s1_ready, s1_adv, s2_adv, in_acc;

  assign out_ready = !out_valid || !out_stall;
  assign s2_ready  = !s2_valid || out_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign s1_adv    = s1_valid && s2_ready;
  assign s2_adv    = s2_valid && out_ready;
  assign in_stall  = clr_active || !s1_ready;
  assign in_acc    = in_valid && !in_stall;

  // read addresses
  logic [SITE_W-1:0] left_site, right_site;

  assign left_site  = (site == '0) ? SITE_LAST : site - 1'b1;
  assign right_site = (site == SITE_LAST) ? '0 : site + 1'b1;

  logic [1:0]            ram_we;
  logic [ROW_W-1:0]      ram_waddr;
  logic                  ram_wdata;
  logic [1:0][ROW_W-1:0] ram_raddr_a;
  logic [1:0][ROW_W-1:0] ram_raddr_b;
  logic [1:0]            ram_rdata_a;
  logic [1:0]            ram_rdata_b;

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      ram_raddr_a[b] = (site[0] == 1'(b)) ? site[SITE_W-1:1] : left_site[SITE_W-1:1];
      ram_raddr_b[b] = right_site[SITE_W-1:1];
    end
  end

  for (genvar g = 0; g < 2; g++) begin : g_bank
    ising1d_ram #(
      .DEPTH (ROWS),
      .DW    (1)
    ) u_bank (
      .clk     (clk),
      .we      (ram_we[g]),
      .waddr   (ram_waddr),
      .wdata   (ram_wdata),
      .re      (in_acc),
      .raddr_a (ram_raddr_a[g]),
      .raddr_b (ram_raddr_b[g]),
      .rdata_a (ram_rdata_a[g]),
      .rdata_b (ram_rdata_b[g])
    );
  end

  // stage 1: decide and write back
  logic [SITE_W-1:0] s1_site, s1_left, s1_right;
  logic              s1_snew;
  logic [DRAW_W-1:0] s1_draw;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_site  <= site;
      s1_left  <= left_site;
      s1_right <= right_site;
      s1_snew  <= proposed_spin;
      s1_draw  <= uniform_draw;
    end
  end

  logic              fwd_valid;
  logic [SITE_W-1:0] fwd_site;
  logic              fwd_spin;

  logic                    par, rd_c, rd_l, rd_r, sp_c, sp_l, sp_r;
  logic                    in_range, same, pass, s1_write, s1_commit, s1_acc;
  logic [1:0]              nsum_idx;
  logic signed [LOC_W-1:0] j2, jn, loc;
  logic signed [DE_W-1:0]  de2, de, s1_de;
  logic [THR_W-1:0]        thr;
  logic [SUM_W-1:0]        spin_total, spin_total_next;

  assign par  = s1_site[0];
  assign rd_c = ram_rdata_a[par];
  assign rd_l = ram_rdata_a[~par];
  assign rd_r = ram_rdata_b[~par];
  assign sp_c = (fwd_valid && fwd_site == s1_site)  ? fwd_spin : rd_c;
  assign sp_l = (fwd_valid && fwd_site == s1_left)  ? fwd_spin : rd_l;
  assign sp_r = (fwd_valid && fwd_site == s1_right) ? fwd_spin : rd_r;

  assign nsum_idx = {1'b0, sp_l} + {1'b0, sp_r};
  assign j2       = {cfg.coupling[Q_W-1], cfg.coupling, 1'b0};

  always_comb begin
    case (nsum_idx)
      2'd0:    jn = -j2;
      2'd2:    jn = j2;
      default: jn = '0;
    endcase
  end

  assign loc       = jn + LOC_W'(cfg.field);
  assign de2       = {loc, 1'b0};
  assign de        = s1_snew ? -de2 : de2;
  assign thr       = s1_snew ? cfg.thr_up[nsum_idx] : cfg.thr_down[nsum_idx];
  assign in_range  = {1'b0, s1_site} < SITE_LIMIT;
  assign same      = s1_snew == sp_c;
  assign pass      = {1'b0, s1_draw} <= thr;
  assign s1_write  = in_range && !same && pass;
  assign s1_acc    = in_range && (same || pass);
  assign s1_de     = s1_write ? de : '0;
  assign s1_commit = s1_adv && s1_write;

  always_comb begin
    spin_total_next = spin_total;
    if (s1_commit) begin
      spin_total_next = s1_snew ? spin_total + SUM_W'(2) : spin_total - SUM_W'(2);
    end
  end

  always_comb begin
    ram_we    = '0;
    ram_waddr = s1_site[SITE_W-1:1];
    ram_wdata = s1_snew;
    if (clr_active) begin
      ram_we    = 2'b11;
      ram_waddr = clr_row;
      ram_wdata = 1'b1;
    end else if (s1_commit) begin
      ram_we[par] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid  <= 1'b0;
      spin_total <= SUM_RESET;
    end else begin
      spin_total <= spin_total_next;
      if (s1_commit) begin
        fwd_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_commit) begin
      fwd_site <= s1_site;
      fwd_spin <= s1_snew;
    end
  end

  // stage 2: hold decision for accumulation
  logic                   s2_accepted;
  logic signed [DE_W-1:0] s2_de;
  logic [SUM_W-1:0]       s2_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_accepted <= s1_acc;
      s2_de       <= s1_de;
      s2_sum      <= spin_total_next;
    end
  end

  // output stage: saturating energy accumulation
  logic signed [E_W:0] e_sum;

  assign e_sum = (E_W + 1)'(energy_total) + (E_W + 1)'(s2_de);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      energy_total <= '0;
    end else begin
      if (out_ready) begin
        out_valid <= s2_valid;
      end
      if (s2_adv) begin
        if (e_sum[E_W] != e_sum[E_W-1]) begin
          energy_total <= e_sum[E_W] ? E_MIN : E_MAX;
        end else begin
          energy_total <= e_sum[E_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      accepted     <= s2_accepted;
      delta_energy <= s2_de;
      spin_sum     <= s2_sum;
    end
  end

  a_no_item_in_clear: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> !s1_valid && !s2_valid)
    else $error("word in flight during clearing pass");

  a_one_bank_write: assert property (@(posedge clk) disable iff (rst)
    !clr_active |-> $onehot0(ram_we))
    else $error("pipeline wrote both banks");

  a_spin_total_hold: assert property (@(posedge clk) disable iff (rst)
    !s1_commit |=> $stable(spin_total))
    else $error("spin total moved without a write");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !s2_accepted) |-> (s2_de == '0))
    else $error("rejected word carries energy change");

  a_energy_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(energy_total))
    else $error("energy total moved under stall");

endmodule
`default_nettype wire
